/* design/pds_pkg.sv */
// Shared types, constants and helpers of the procedure declaration scanner.
package pds_pkg;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_S = 8'h73;

    // Keyword lengths, stored as last position index
    localparam logic [2:0] KW_SUB_LAST = 3'd2;
    localparam logic [2:0] KW_FN_LAST  = 3'd7;

    // Configuration register indexes
    localparam logic CFG_PREFIX_CHARS = 1'b0;
    localparam logic CFG_PREFIX_LEN   = 1'b1;

    // Controller states: scan phases, then the name emission steps
    typedef enum logic [3:0] {
        ST_LEAD,
        ST_KEYWORD,
        ST_NEED_SPACE,
        ST_SKIP_SPACE,
        ST_NAME,
        ST_IGNORE,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic kw_start;
        logic kw_step;
        logic name_clear;
        logic name_push;
        logic emit_start;
        logic emit_load;
    } pds_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_nl;
        logic is_ws;
        logic is_alnum;
        logic lead_match;
        logic kw_match;
        logic kw_done;
        logic prefix_pass;
        logic emit_last;
        logic out_free;
    } pds_status_t;

    // ASCII lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Expected keyword byte at a position
    function automatic logic [7:0] kw_char(input logic is_fn, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        if (is_fn) begin
            unique case (pos)
                3'd0: r = 8'h66;
                3'd1: r = 8'h75;
                3'd2: r = 8'h6E;
                3'd3: r = 8'h63;
                3'd4: r = 8'h74;
                3'd5: r = 8'h69;
                3'd6: r = 8'h6F;
                3'd7: r = 8'h6E;
                default: r = 8'h00;
            endcase
        end else begin
            unique case (pos)
                3'd0: r = 8'h73;
                3'd1: r = 8'h75;
                3'd2: r = 8'h62;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

/* design/procedure_declaration_scanner.sv */
// A byte that ends no name is taken and the next byte can follow at once.
// A byte that ends a name adds a check state, then for a kept name a RAM read state and a
// result load state per name byte (the load waits while the output is not free); input is
// held off until the final result is loaded. One text byte is taken per cycle while no name
// is checked or emitted; each result needs its own registered name RAM read.
// Reset: synchronous, active low; clears scan and result state and config, not the name RAM.
module procedure_declaration_scanner #(
    parameter int MAX_NAME   = 32,
    parameter int PREFIX_MAX = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Text input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_char
    input  logic        s_tlast,   // end_of_text
    // Name results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] name_char, [8] char_valid, [9] is_function,
                                   // [10] truncated, [15:11] zero
    output logic        m_tlast,   // last
    // Configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata
);

    pds_pkg::pds_cmd_t    cmd;
    pds_pkg::pds_status_t status;

    pds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    pds_datapath #(
        .MAX_NAME   (MAX_NAME),
        .PREFIX_MAX (PREFIX_MAX)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .text_char (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* design/pds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/pds_datapath.sv */
// Datapath: byte classes, keyword match, name store, prefix check, result register.
module pds_datapath #(
    parameter int MAX_NAME   = 32,
    parameter int PREFIX_MAX = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          text_char,
    input  pds_pkg::pds_cmd_t   cmd,
    output pds_pkg::pds_status_t status,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_wdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [15:0]         m_tdata,
    output logic                m_tlast
);

    localparam int LEN_W  = $clog2(MAX_NAME + 1);
    localparam int ADDR_W = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
    localparam int HEAD_N = (PREFIX_MAX < MAX_NAME) ? PREFIX_MAX : MAX_NAME;
    localparam int CW     = (LEN_W > 4) ? LEN_W : 4;

    // Configuration
    logic [8*PREFIX_MAX-1:0] prefix_reg;
    logic [3:0]              plen_reg;

    // Keyword and name state
    logic [2:0]       kw_pos_reg, kw_pos_next;
    logic             is_fn_reg, is_fn_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       head_reg [HEAD_N];

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg;
    logic       out_cv_reg, out_fn_reg, out_tr_reg, out_last_reg;

    logic [7:0] lc;
    logic       ram_we;
    logic [7:0] ram_rdata;
    logic [3:0] plen_eff;
    logic       mismatch;
    logic       name_empty;

    pds_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (text_char),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Byte classification, keyword compare, prefix filter over the head bytes and emit status
    always_comb begin
        lc = pds_pkg::to_lower(text_char);
        status.is_nl    = (text_char == pds_pkg::CH_NEWLINE);
        status.is_ws    = (text_char == pds_pkg::CH_SPACE) ||
                          (text_char >= pds_pkg::CH_TAB && text_char <= pds_pkg::CH_CR);
        status.is_alnum = (text_char >= 8'h30 && text_char <= 8'h39) ||
                          (text_char >= 8'h41 && text_char <= 8'h5A) ||
                          (text_char >= 8'h61 && text_char <= 8'h7A);
        status.lead_match = (lc == pds_pkg::CH_LOWER_F) || (lc == pds_pkg::CH_LOWER_S);
        status.kw_match   = (lc == pds_pkg::kw_char(is_fn_reg, kw_pos_reg));
        status.kw_done    = (kw_pos_reg == (is_fn_reg ? pds_pkg::KW_FN_LAST
                                                      : pds_pkg::KW_SUB_LAST));

        plen_eff = (plen_reg > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX) : plen_reg;
        mismatch = 1'b0;
        for (int k = 0; k < HEAD_N; k++) begin
            if (4'(k) < plen_eff && head_reg[k] != prefix_reg[8*k +: 8]) begin
                mismatch = 1'b1;
            end
        end
        status.prefix_pass = (plen_eff == 4'd0) ||
                             ((CW'(len_reg) >= CW'(plen_eff)) && !mismatch);
        name_empty       = (len_reg == '0);
        status.emit_last = name_empty || ((idx_reg + LEN_W'(1)) == len_reg);
        status.out_free  = !out_valid_reg || m_tready;
    end

    // Next state of the keyword, name and index registers
    always_comb begin
        kw_pos_next = kw_pos_reg;
        is_fn_next  = is_fn_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        ram_we      = 1'b0;
        if (cmd.kw_start) begin
            is_fn_next  = (lc == pds_pkg::CH_LOWER_F);
            kw_pos_next = 3'd1;
        end else if (cmd.kw_step) begin
            kw_pos_next = kw_pos_reg + 3'd1;
        end
        if (cmd.name_clear) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (cmd.name_push) begin
            if (len_reg < LEN_W'(MAX_NAME)) begin
                ram_we   = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.emit_start) begin
            idx_next = '0;
        end else if (cmd.emit_load) begin
            idx_next = idx_reg + LEN_W'(1);
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.emit_load) begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_pos_reg    <= '0;
            is_fn_reg     <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            prefix_reg    <= '0;
            plen_reg      <= '0;
        end else begin
            kw_pos_reg    <= kw_pos_next;
            is_fn_reg     <= is_fn_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == pds_pkg::CFG_PREFIX_CHARS) begin
                prefix_reg <= cfg_wdata[8*PREFIX_MAX-1:0];
            end
            if (cfg_we && cfg_index == pds_pkg::CFG_PREFIX_LEN) begin
                plen_reg <= cfg_wdata[3:0];
            end
        end
    end

    // Head copy of the first name bytes for the prefix check
    always_ff @(posedge aclk) begin
        for (int k = 0; k < HEAD_N; k++) begin
            if (ram_we && len_reg == LEN_W'(k)) begin
                head_reg[k] <= text_char;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_char_reg <= name_empty ? 8'h00 : ram_rdata;
            out_cv_reg   <= !name_empty;
            out_fn_reg   <= is_fn_reg;
            out_tr_reg   <= ovf_reg;
            out_last_reg <= status.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_tr_reg, out_fn_reg, out_cv_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* design/pds_ctrl.sv */
// Controller: scan phase state machine and name emission sequencing.
module pds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tlast,
    input  pds_pkg::pds_status_t status,
    output pds_pkg::pds_cmd_t    cmd
);

    pds_pkg::ctrl_state_t state_reg, state_next;
    pds_pkg::ctrl_state_t phase;
    pds_pkg::ctrl_state_t ret_state;
    logic                 ret_lead_reg, ret_lead_next;
    logic                 accept;
    logic                 emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pds_pkg::ST_LEAD;
            ret_lead_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            ret_lead_reg <= ret_lead_next;
        end
    end

    always_comb begin
        s_tready      = (state_reg != pds_pkg::ST_CHECK) &&
                        (state_reg != pds_pkg::ST_EMIT_RD) &&
                        (state_reg != pds_pkg::ST_EMIT_LD);
        accept        = s_tvalid && s_tready;
        cmd           = '0;
        state_next    = state_reg;
        ret_lead_next = ret_lead_reg;
        phase         = state_reg;
        emit          = 1'b0;
        ret_state     = ret_lead_reg ? pds_pkg::ST_LEAD : pds_pkg::ST_IGNORE;

        unique case (state_reg)
            pds_pkg::ST_CHECK: begin
                cmd.emit_start = 1'b1;
                state_next = status.prefix_pass ? pds_pkg::ST_EMIT_RD : ret_state;
            end
            pds_pkg::ST_EMIT_RD: begin
                state_next = pds_pkg::ST_EMIT_LD;
            end
            pds_pkg::ST_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next = status.emit_last ? ret_state : pds_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                if (accept) begin
                    // Newline ends the line and any open name
                    if (status.is_nl) begin
                        if (state_reg == pds_pkg::ST_NEED_SPACE) begin
                            cmd.name_clear = 1'b1;
                            emit = 1'b1;
                        end else if (state_reg == pds_pkg::ST_SKIP_SPACE ||
                                     state_reg == pds_pkg::ST_NAME) begin
                            emit = 1'b1;
                        end
                        phase = pds_pkg::ST_LEAD;
                    end else begin
                        unique case (state_reg)
                            pds_pkg::ST_LEAD: begin
                                if (!status.is_ws) begin
                                    cmd.kw_start = 1'b1;
                                    phase = status.lead_match ? pds_pkg::ST_KEYWORD
                                                              : pds_pkg::ST_IGNORE;
                                end
                            end
                            pds_pkg::ST_KEYWORD: begin
                                if (status.kw_match) begin
                                    cmd.kw_step = 1'b1;
                                    phase = status.kw_done ? pds_pkg::ST_NEED_SPACE
                                                           : pds_pkg::ST_KEYWORD;
                                end else begin
                                    phase = pds_pkg::ST_IGNORE;
                                end
                            end
                            pds_pkg::ST_NEED_SPACE: begin
                                if (status.is_ws) begin
                                    cmd.name_clear = 1'b1;
                                    phase = pds_pkg::ST_SKIP_SPACE;
                                end else begin
                                    phase = pds_pkg::ST_IGNORE;
                                end
                            end
                            pds_pkg::ST_SKIP_SPACE, pds_pkg::ST_NAME: begin
                                if (state_reg == pds_pkg::ST_SKIP_SPACE && status.is_ws) begin
                                    phase = pds_pkg::ST_SKIP_SPACE;
                                end else if (status.is_alnum) begin
                                    cmd.name_push = 1'b1;
                                    phase = pds_pkg::ST_NAME;
                                end else begin
                                    emit = 1'b1;
                                    phase = pds_pkg::ST_IGNORE;
                                end
                            end
                            default: begin
                                phase = pds_pkg::ST_IGNORE;
                            end
                        endcase
                    end

                    // End of text closes an open name and restarts the line
                    if (s_tlast) begin
                        if (phase == pds_pkg::ST_SKIP_SPACE || phase == pds_pkg::ST_NAME) begin
                            emit = 1'b1;
                        end
                        phase = pds_pkg::ST_LEAD;
                    end

                    if (emit) begin
                        ret_lead_next = (phase == pds_pkg::ST_LEAD);
                        state_next    = pds_pkg::ST_CHECK;
                    end else begin
                        state_next = phase;
                    end
                end
            end
        endcase
    end

endmodule

/* sim/procedure_declaration_scanner_tb.sv */
// Self-checking bench for the procedure declaration scanner: script text in, found names out.
module procedure_declaration_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int NAME_DEPTH    = 32;
    localparam int PREFIX_BYTES  = 8;
    localparam int SETTLE_CYCLES = 80;    // covers the check state and the emission of a name, with margin
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int N_PHASES      = 6;

    localparam logic [63:0] KW_FUNCTION = "function";
    localparam logic [23:0] KW_SUB      = "sub";

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       drain;   // sender waits for all names out before this beat
    } text_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       fn;
        logic       trunc;
        logic       last;
    } name_beat_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = pds_pkg::CFG_PREFIX_CHARS;
    logic [63:0] cfg_wdata = 64'h0;

    procedure_declaration_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Pending text and expected name beats
    text_beat_t text_queue[$];
    name_beat_t name_expect[$];
    int         err_count = 0;

    // Scanner shadow state
    pds_pkg::ctrl_state_t scan_state = pds_pkg::ST_LEAD;
    logic [3:0]  kw_pos     = 4'd0;
    logic        kw_fn      = 1'b0;
    logic [7:0]  name_buf[NAME_DEPTH];
    int          name_len   = 0;
    logic        name_ovf   = 1'b0;
    logic [63:0] pfx_chars  = 64'h0;
    logic [3:0]  pfx_len    = 4'd0;

    function automatic bit is_space(input logic [7:0] c);
        return c == pds_pkg::CH_SPACE || (c >= pds_pkg::CH_TAB && c <= pds_pkg::CH_CR);
    endfunction

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] kw_byte(input logic fn, input logic [3:0] pos);
        if (fn) begin
            return KW_FUNCTION[8*(7-pos) +: 8];
        end
        return KW_SUB[8*(2-pos) +: 8];
    endfunction

    // Advance the keyword match; 0 on mismatch
    function automatic bit kw_accept(input logic [7:0] c);
        logic [3:0] kw_len;
        kw_len = kw_fn ? 4'd8 : 4'd3;
        if (kw_pos >= kw_len || fold_case(c) != kw_byte(kw_fn, kw_pos)) begin
            return 1'b0;
        end
        kw_pos = kw_pos + 4'd1;
        if (kw_pos == kw_len) begin
            scan_state = pds_pkg::ST_NEED_SPACE;
        end
        return 1'b1;
    endfunction

    // Prefix filter, then one beat per stored byte (or one empty beat)
    function automatic void queue_name_beats();
        int plen;
        name_beat_t nb;
        plen = (pfx_len > PREFIX_BYTES) ? PREFIX_BYTES : int'(pfx_len);
        if (plen > 0) begin
            if (name_len < plen) begin
                return;
            end
            for (int i = 0; i < plen; i++) begin
                if (name_buf[i] != pfx_chars[8*i +: 8]) begin
                    return;
                end
            end
        end
        nb.fn    = kw_fn;
        nb.trunc = name_ovf;
        if (name_len == 0) begin
            nb.ch   = 8'h00;
            nb.cv   = 1'b0;
            nb.last = 1'b1;
            name_expect.push_back(nb);
        end else begin
            for (int i = 0; i < name_len; i++) begin
                nb.ch   = name_buf[i];
                nb.cv   = 1'b1;
                nb.last = (i + 1 == name_len);
                name_expect.push_back(nb);
            end
        end
    endfunction

    // One accepted text byte
    function automatic void scan_text_byte(input logic [7:0] c, input logic eot);
        if (c == pds_pkg::CH_NEWLINE) begin
            if (scan_state == pds_pkg::ST_NEED_SPACE) begin
                name_len = 0;
                name_ovf = 1'b0;
                queue_name_beats();
            end else if (scan_state == pds_pkg::ST_SKIP_SPACE ||
                         scan_state == pds_pkg::ST_NAME) begin
                queue_name_beats();
            end
            scan_state = pds_pkg::ST_LEAD;
        end else begin
            case (scan_state)
                pds_pkg::ST_LEAD: begin
                    if (!is_space(c)) begin
                        kw_pos     = 4'd0;
                        kw_fn      = (fold_case(c) == pds_pkg::CH_LOWER_F);
                        scan_state = pds_pkg::ST_KEYWORD;
                        if (!kw_accept(c)) begin
                            scan_state = pds_pkg::ST_IGNORE;
                        end
                    end
                end
                pds_pkg::ST_KEYWORD: begin
                    if (!kw_accept(c)) begin
                        scan_state = pds_pkg::ST_IGNORE;
                    end
                end
                pds_pkg::ST_NEED_SPACE: begin
                    if (is_space(c)) begin
                        name_len   = 0;
                        name_ovf   = 1'b0;
                        scan_state = pds_pkg::ST_SKIP_SPACE;
                    end else begin
                        scan_state = pds_pkg::ST_IGNORE;
                    end
                end
                pds_pkg::ST_SKIP_SPACE, pds_pkg::ST_NAME: begin
                    if (!(scan_state == pds_pkg::ST_SKIP_SPACE && is_space(c))) begin
                        if (is_alnum(c)) begin
                            scan_state = pds_pkg::ST_NAME;
                            if (name_len < NAME_DEPTH) begin
                                name_buf[name_len] = c;
                                name_len = name_len + 1;
                            end else begin
                                name_ovf = 1'b1;
                            end
                        end else begin
                            queue_name_beats();
                            scan_state = pds_pkg::ST_IGNORE;
                        end
                    end
                end
                default: scan_state = pds_pkg::ST_IGNORE;
            endcase
        end
        // end of text flushes an open name
        if (eot) begin
            if (scan_state == pds_pkg::ST_SKIP_SPACE || scan_state == pds_pkg::ST_NAME) begin
                queue_name_beats();
            end
            scan_state = pds_pkg::ST_LEAD;
            kw_pos     = 4'd0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        err_count = err_count + 1;
    endtask

    task automatic check_name_beat();
        name_beat_t want;
        if (name_expect.size() == 0) begin
            report_mismatch("unexpected name beat", 16'h0, {4'h0, m_tlast, m_tdata[10:0]});
            return;
        end
        want = name_expect.pop_front();
        if (m_tdata[7:0] != want.ch)
            report_mismatch("name_char", 16'(want.ch), 16'(m_tdata[7:0]));
        if (m_tdata[8] != want.cv)
            report_mismatch("char_valid", 16'(want.cv), 16'(m_tdata[8]));
        if (m_tdata[9] != want.fn)
            report_mismatch("is_function", 16'(want.fn), 16'(m_tdata[9]));
        if (m_tdata[10] != want.trunc)
            report_mismatch("truncated", 16'(want.trunc), 16'(m_tdata[10]));
        if (m_tlast != want.last)
            report_mismatch("last", 16'(want.last), 16'(m_tlast));
    endtask

    // Sampling at the rising edge: register writes, text beats, name beats
    logic in_taken = 1'b0;
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == pds_pkg::CFG_PREFIX_CHARS) begin
                    pfx_chars = cfg_wdata;
                end else begin
                    pfx_len = cfg_wdata[3:0];
                end
            end
            if (s_tvalid && s_tready) begin
                scan_text_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_name_beat();
            end
        end
    end

    // Text driver: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(negedge aclk) begin
        text_beat_t tb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            // beat still waiting
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (text_queue.size() == 0 ||
                     (text_queue[0].drain && name_expect.size() != 0)) begin
            s_tvalid <= 1'b0;
        end else begin
            tb = text_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= tb.ch;
            s_tlast  <= tb.eot;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 20);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Name receiver: stall patterns in randomly chosen modes, plus one long hold on request
    logic hold_req  = 1'b0;
    logic hold_ack  = 1'b0;
    int   hold_left = 0;
    int   rx_cycle  = 0;
    int   rx_mode   = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) begin
                rx_mode <= $urandom_range(0, 3);
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= (rx_cycle % 4 != 3);
                2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_cycle % 5 == 0);
            endcase
        end
    end

    // Watchdog on cycles without any handshake
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL procedure_declaration_scanner");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus helpers
    int          pushed_bytes = 0;
    logic [63:0] cur_chars    = 64'h0;
    int          cur_plen     = 0;

    function automatic void push_byte(input logic [7:0] c, input logic eot);
        text_beat_t tb;
        tb.ch    = c;
        tb.eot   = eot;
        tb.drain = 1'b0;
        text_queue.push_back(tb);
        pushed_bytes = pushed_bytes + 1;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i], 1'b0);
        end
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'h30 + 8'(r);
        if (r < 36) return 8'h41 + 8'(r - 10);
        return 8'h61 + 8'(r - 36);
    endfunction

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(0, 4);
        if (r == 4) return pds_pkg::CH_SPACE;
        if (r == 0) return pds_pkg::CH_TAB;
        return 8'd10 + 8'(r);   // vertical tab, form feed, carriage return
    endfunction

    function automatic logic [63:0] rand_prefix();
        logic [63:0] p;
        for (int i = 0; i < PREFIX_BYTES; i++) begin
            p[8*i +: 8] = rand_alnum();
        end
        return p;
    endfunction

    // Line of random bytes
    function automatic void gen_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end
        push_byte(pds_pkg::CH_NEWLINE, 1'b0);
    endfunction

    // Declaration line with random content, sometimes broken
    function automatic void gen_decl();
        int         start, n_lead, n_sep, nlen, kind;
        logic       fn;
        logic [7:0] c;
        start  = text_queue.size();
        n_lead = $urandom_range(0, 2);
        for (int i = 0; i < n_lead; i++) begin
            push_byte(rand_space(), 1'b0);
        end
        fn = 1'($urandom_range(0, 1));
        for (int i = 0; i < (fn ? 8 : 3); i++) begin
            c = kw_byte(fn, 4'(i));
            if ($urandom_range(0, 1) == 1) c = c - 8'd32;
            if ($urandom_range(0, 24) == 0) c = rand_alnum();
            push_byte(c, 1'b0);
        end
        if ($urandom_range(0, 5) == 0) text_queue[start].drain = 1'b1;
        // keyword closing the text
        if ($urandom_range(0, 11) == 0) begin
            text_queue[$].eot = 1'b1;
            return;
        end
        kind = $urandom_range(0, 9);
        if (kind == 1) begin
            push_byte(pds_pkg::CH_NEWLINE, 1'b0);
            return;
        end
        n_sep = (kind == 0) ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < n_sep; i++) begin
            push_byte(rand_space(), 1'b0);
        end
        if (cur_plen > 0 && $urandom_range(0, 2) != 0) begin
            for (int i = 0; i < cur_plen; i++) begin
                push_byte(cur_chars[8*i +: 8], 1'b0);
            end
        end
        kind = $urandom_range(0, 19);
        nlen = (kind == 0) ? 0 : (kind == 1) ? $urandom_range(33, 40) : $urandom_range(1, 8);
        for (int i = 0; i < nlen; i++) begin
            push_byte(rand_alnum(), 1'b0);
        end
        // line ending
        kind = $urandom_range(0, 9);
        if (kind <= 4) begin
            push_byte(pds_pkg::CH_NEWLINE, 1'b0);
        end else if (kind == 5) begin
            push_text("(x) 'sub y\n");
        end else if (kind == 6) begin
            text_queue[$].eot = 1'b1;
        end else if (kind == 7) begin
            push_byte(pds_pkg::CH_SPACE, 1'b1);
        end else if (kind == 8) begin
            push_text("()\n");
        end else begin
            push_byte(8'($urandom_range(0, 255)), 1'b0);
            push_byte(pds_pkg::CH_NEWLINE, 1'b0);
        end
    endfunction

    task automatic write_reg(input logic idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // All text taken, all names out, then let a rejected name finish its check
    task automatic wait_idle();
        while (text_queue.size() != 0 || s_tvalid || name_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Phases: reset setting, short prefix, full prefix, no filter with ones,
    // oversized length, prefix of zero bytes
    logic [63:0] phase_chars[N_PHASES];
    logic [3:0]  phase_len[N_PHASES];
    int          phase_budget;

    initial begin
        phase_chars[0] = 64'h0;                  phase_len[0] = 4'd0;
        phase_chars[1] = rand_prefix();          phase_len[1] = 4'd2;
        phase_chars[2] = rand_prefix();          phase_len[2] = 4'd8;
        phase_chars[3] = 64'hFFFF_FFFF_FFFF_FFFF; phase_len[3] = 4'd0;
        phase_chars[4] = rand_prefix();          phase_len[4] = 4'd15;
        phase_chars[5] = 64'h0;                  phase_len[5] = 4'd4;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                // leading space, mixed case, plain name
                push_text(" Sub Ab\n");
                // newline right after the keyword: empty name
                push_text("function\n");
                // byte extremes on an ignored line
                push_byte(8'h00, 1'b0);
                push_byte(8'hFF, 1'b0);
                push_byte(pds_pkg::CH_NEWLINE, 1'b0);
                // keyword as the final byte of the text
                push_text("suB");
                text_queue[$].eot = 1'b1;
            end else begin
                wait_idle();
                write_reg(pds_pkg::CFG_PREFIX_CHARS, phase_chars[ph]);
                write_reg(pds_pkg::CFG_PREFIX_LEN, {60'h0, phase_len[ph]});
            end
            cur_chars = phase_chars[ph];
            cur_plen  = (phase_len[ph] > PREFIX_BYTES) ? PREFIX_BYTES : int'(phase_len[ph]);
            if (ph == 1) begin
                hold_req <= ~hold_req;
            end
            phase_budget = pushed_bytes + ((ph == N_PHASES - 1) ? 12 : 16);
            while (pushed_bytes < phase_budget) begin
                if ($urandom_range(0, 4) == 0) begin
                    gen_noise();
                end else begin
                    gen_decl();
                end
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("PASS procedure_declaration_scanner");
        end else begin
            $display("FAIL procedure_declaration_scanner");
        end
        $finish;
    end

endmodule
